>>> design/tstd_pkg.sv
// ----------------------------------------------------------------------------
// tstd_pkg: shared types and constants for the touch swipe/tap detector
// Gesture codes, configuration register indexes, register widths and
// reset values.
// ----------------------------------------------------------------------------
package tstd_pkg;

    // Gesture codes as reported on the result channel
    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_RIGHT = 3'd1,
        GEST_LEFT  = 3'd2,
        GEST_DOWN  = 3'd3,
        GEST_UP    = 3'd4,
        GEST_CLICK = 3'd5
    } gesture_t;

    localparam int GEST_W = 3;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWIPE_MAX_MS   = 2'd0,
        CFG_SWIPE_MIN_DIST = 2'd1,
        CFG_CLICK_MAX_DIST = 2'd2
    } cfg_index_t;

    // Register widths
    localparam int TIME_W   = 32;
    localparam int MAX_MS_W = 16;
    localparam int DIST_W   = 12;

    // Register reset values
    localparam logic [MAX_MS_W-1:0] SWIPE_MAX_MS_RST   = 16'd500;
    localparam logic [DIST_W-1:0]   SWIPE_MIN_DIST_RST = 12'd30;
    localparam logic [DIST_W-1:0]   CLICK_MAX_DIST_RST = 12'd10;

endpackage

>>> design/tstd_classify.sv
// ----------------------------------------------------------------------------
// tstd_classify: stroke classifier
// Combinational decision on release: duration check, dominant axis swipe,
// or click at the last point.
// ----------------------------------------------------------------------------
module tstd_classify
    import tstd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  release_stroke,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [TIME_W-1:0]     start_time,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] last_x,
    input  logic [COORD_BITS-1:0] last_y,
    input  logic [MAX_MS_W-1:0]   swipe_max_ms,
    input  logic [DIST_W-1:0]     swipe_min_dist,
    input  logic [DIST_W-1:0]     click_max_dist,
    output gesture_t              gesture,
    output logic [COORD_BITS-1:0] click_x,
    output logic [COORD_BITS-1:0] click_y
);

    // compare width covers both coordinate travel and threshold registers
    localparam int CMP_W = (COORD_BITS > DIST_W) ? COORD_BITS : DIST_W;

    logic [TIME_W-1:0]     duration;
    logic                  in_time;
    logic                  x_pos_dir;
    logic                  y_pos_dir;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [CMP_W-1:0]      adx_w;
    logic [CMP_W-1:0]      ady_w;
    logic [CMP_W-1:0]      min_w;
    logic [CMP_W-1:0]      click_w;

    // wrapping duration and per-axis travel
    always_comb begin
        duration  = now_ms - start_time;
        in_time   = (duration <= {{(TIME_W-MAX_MS_W){1'b0}}, swipe_max_ms});
        x_pos_dir = (last_x > start_x);
        y_pos_dir = (last_y > start_y);
        adx       = x_pos_dir ? (last_x - start_x) : (start_x - last_x);
        ady       = y_pos_dir ? (last_y - start_y) : (start_y - last_y);
        adx_w     = CMP_W'(adx);
        ady_w     = CMP_W'(ady);
        min_w     = CMP_W'(swipe_min_dist);
        click_w   = CMP_W'(click_max_dist);
    end

    // gesture decision; coordinates only on a click
    always_comb begin
        gesture = GEST_NONE;
        click_x = '0;
        click_y = '0;
        if (release_stroke && in_time) begin
            if ((adx_w > ady_w) && (adx_w >= min_w)) begin
                gesture = x_pos_dir ? GEST_RIGHT : GEST_LEFT;
            end else if ((ady_w > adx_w) && (ady_w >= min_w)) begin
                gesture = y_pos_dir ? GEST_DOWN : GEST_UP;
            end else if ((adx_w < click_w) && (ady_w < click_w)) begin
                gesture = GEST_CLICK;
                click_x = last_x;
                click_y = last_y;
            end
        end
    end

endmodule

>>> design/tstd_out_buf.sv
// ----------------------------------------------------------------------------
// tstd_out_buf: two-entry result buffer
// Output register plus skid register, so the input side keeps taking
// samples while one result waits for the consumer.
// ----------------------------------------------------------------------------
module tstd_out_buf #(
    parameter int DATA_W = 27
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              push;
    logic              pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;

    // control: skid fills only when the output register is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (out_valid_reg && !pop && push) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

>>> design/touch_swipe_tap_detector.sv
// ----------------------------------------------------------------------------
// touch_swipe_tap_detector: swipe and tap gesture detector
// Classifies touch strokes from a stream of touch-controller samples.
// ----------------------------------------------------------------------------
// One result is produced for every accepted sample, in order. A sample is
// classified in the cycle it is transferred, against the stroke state held
// in registers; its result is registered in the output register, or in the
// skid register while a result is held. Throughput is one sample per clock;
// s_ready drops only when two results are waiting unread (output register
// and skid register both full). Configuration writes take effect once
// registered and are meant to happen while no results are outstanding.
// ----------------------------------------------------------------------------
module touch_swipe_tap_detector
    import tstd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_touched,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [TIME_W-1:0]     s_now_ms,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [GEST_W-1:0]     m_gesture,
    output logic [COORD_BITS-1:0] m_click_x,
    output logic [COORD_BITS-1:0] m_click_y
);

    localparam int RES_W = GEST_W + 2 * COORD_BITS;

    logic [MAX_MS_W-1:0]   swipe_max_ms_reg;
    logic [DIST_W-1:0]     swipe_min_dist_reg;
    logic [DIST_W-1:0]     click_max_dist_reg;

    logic                  tracking_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] last_x_reg;
    logic [COORD_BITS-1:0] last_y_reg;
    logic [TIME_W-1:0]     start_time_reg;

    logic                  sample_xfer;
    gesture_t              gesture;
    logic [COORD_BITS-1:0] click_x;
    logic [COORD_BITS-1:0] click_y;
    logic [RES_W-1:0]      res_data;
    logic [RES_W-1:0]      out_data;

    assign sample_xfer = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swipe_max_ms_reg   <= SWIPE_MAX_MS_RST;
            swipe_min_dist_reg <= SWIPE_MIN_DIST_RST;
            click_max_dist_reg <= CLICK_MAX_DIST_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SWIPE_MAX_MS:   swipe_max_ms_reg   <= cfg_wdata;
                CFG_SWIPE_MIN_DIST: swipe_min_dist_reg <= cfg_wdata[DIST_W-1:0];
                CFG_CLICK_MAX_DIST: click_max_dist_reg <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // stroke state: start on first touch, follow while touched, end on release
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg   <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            start_time_reg <= '0;
        end else if (sample_xfer) begin
            if (s_touched) begin
                last_x_reg <= s_pos_x;
                last_y_reg <= s_pos_y;
                if (!tracking_reg) begin
                    tracking_reg   <= 1'b1;
                    start_x_reg    <= s_pos_x;
                    start_y_reg    <= s_pos_y;
                    start_time_reg <= s_now_ms;
                end
            end else begin
                tracking_reg <= 1'b0;
            end
        end
    end

    // classification of the current sample
    tstd_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .release_stroke (!s_touched && tracking_reg),
        .now_ms         (s_now_ms),
        .start_time     (start_time_reg),
        .start_x        (start_x_reg),
        .start_y        (start_y_reg),
        .last_x         (last_x_reg),
        .last_y         (last_y_reg),
        .swipe_max_ms   (swipe_max_ms_reg),
        .swipe_min_dist (swipe_min_dist_reg),
        .click_max_dist (click_max_dist_reg),
        .gesture        (gesture),
        .click_x        (click_x),
        .click_y        (click_y)
    );

    assign res_data = {gesture, click_x, click_y};

    // result register with skid
    tstd_out_buf #(
        .DATA_W (RES_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_gesture = out_data[RES_W-1 -: GEST_W];
    assign m_click_x = out_data[2*COORD_BITS-1 -: COORD_BITS];
    assign m_click_y = out_data[COORD_BITS-1:0];

endmodule

>>> design/tstd_checker.sv
// ----------------------------------------------------------------------------
// tstd_checker: port-level checks for the touch swipe/tap detector
// Watches the top-level ports and flags behavior the design must never show.
// ----------------------------------------------------------------------------
module tstd_checker
    import tstd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [GEST_W-1:0]     m_gesture,
    input logic [COORD_BITS-1:0] m_click_x,
    input logic [COORD_BITS-1:0] m_click_y
);

    // click coordinates are zero on every non-click result
    a_coords_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_gesture != GEST_CLICK) |-> (m_click_x == '0 && m_click_y == '0))
        else $error("click coordinates nonzero on a non-click result");

    // no result appears right out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input side stalls only behind a result that was held back
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready dropped without a held result");

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_gesture)
            && $stable(m_click_x) && $stable(m_click_y)))
        else $error("held result changed");

endmodule

bind touch_swipe_tap_detector tstd_checker #(
    .COORD_BITS (COORD_BITS)
) u_tstd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_gesture (m_gesture),
    .m_click_x (m_click_x),
    .m_click_y (m_click_y)
);
